[rtl/vector3_alu_unit_assert.svh]
// Assertion macros for the vector arithmetic unit.
// Used by the top level only; depends on nothing else.
`ifndef VECTOR3_ALU_UNIT_ASSERT_SVH
`define VECTOR3_ALU_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define V3A_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define V3A_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[rtl/v3a_pkg.sv]
// Package for the vector arithmetic unit: action codes, widths and the request type.
// No dependencies.
`default_nettype none
package v3a_pkg;
    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int PROD_BITS = 2 * WORD_BITS + 2;
    localparam int ROOT_BITS = WORD_BITS + 1;
    localparam int QUO_BITS = WORD_BITS + FRAC_BITS + 1;

    typedef enum logic [3:0] {
        ACT_ADD = 4'd0, ACT_SUB = 4'd1, ACT_NEG = 4'd2, ACT_SCALE = 4'd3,
        ACT_DOT = 4'd4, ACT_CROSS = 4'd5, ACT_SQNORM = 4'd6, ACT_NORM = 4'd7,
        ACT_NORMALIZE = 4'd8, ACT_DIST = 4'd9, ACT_EQUAL = 4'd10
    } t_action;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [PROD_BITS-1:0] t_wide;

    typedef struct packed {
        logic [3:0] action;
        t_word ax, ay, az, bx, by, bz, k;
    } t_req;

    function automatic t_word sat_word(input t_wide v, output logic ovf);
        t_wide maxv, minv;
        maxv = t_wide'({1'b0, {(WORD_BITS-1){1'b1}}});
        minv = -maxv - t_wide'(1);
        ovf = 1'b0;
        if (v > maxv) begin
            ovf = 1'b1;
            return t_word'(maxv);
        end
        if (v < minv) begin
            ovf = 1'b1;
            return t_word'(minv);
        end
        return t_word'(v);
    endfunction
endpackage
`default_nettype wire

[rtl/vector3_alu_unit.sv]
// Top level of the 3-component vector arithmetic unit in signed Q16.16.
// Depends on v3a_pkg, v3a_sqrt, v3a_div and vector3_alu_unit_assert.svh.
//
//  channel   handshake            payload
//  request   i_start / o_busy     i_action, i_ax..i_bz, i_factor
//  result    o_strobe             o_rx, o_ry, o_rz, o_scalar_out, flags
//
// One request is taken every cycle; o_busy is held low.
// The accepting edge loads the input register; a request then passes through
// 2 arithmetic stages, 34 square root and 50 divider stages (each count includes its
// input register) and the output stage; both units resolve one bit per stage.
// Every request flows through all stages so results keep request order.
// Reset clears the valid bits only; the receiver cannot stall.
`default_nettype none
module vector3_alu_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [3:0]  i_action,
    input  wire logic [31:0] i_ax,
    input  wire logic [31:0] i_ay,
    input  wire logic [31:0] i_az,
    input  wire logic [31:0] i_bx,
    input  wire logic [31:0] i_by,
    input  wire logic [31:0] i_bz,
    input  wire logic [31:0] i_factor,
    output logic             o_strobe,
    output logic [31:0]      o_rx,
    output logic [31:0]      o_ry,
    output logic [31:0]      o_rz,
    output logic [31:0]      o_scalar_out,
    output logic             o_equal_flag,
    output logic             o_overflow_flag,
    output logic             o_zero_div_flag
);
    `include "vector3_alu_unit_assert.svh"

    localparam int WB = v3a_pkg::WORD_BITS;
    localparam int FB = v3a_pkg::FRAC_BITS;
    localparam int PB = v3a_pkg::PROD_BITS;
    localparam int RB = v3a_pkg::ROOT_BITS;
    localparam int QB = v3a_pkg::QUO_BITS;
    localparam int DLY = RB + QB + 1;
    localparam int PLEN = 3 + DLY;

    typedef logic signed [WB:0] t_diff;
    typedef logic signed [2*WB+1:0] t_prod;

    logic [PLEN:0] r_vld;
    v3a_pkg::t_req r_s0;
    t_diff r_p0 [0:5];
    t_diff r_p1 [0:5];
    t_prod r_prod [0:5];
    logic [WB:0] r_add [0:2];
    logic [3:0]  r_act1, r_act2;
    logic        r_eq1, r_eq2;
    v3a_pkg::t_wide r_res [0:3];
    logic [WB-1:0] r_sgn_mag [0:2];
    logic [2:0]  r_neg2;

    logic [3:0]  r_act_d [0:DLY];
    logic        r_eq_d  [0:DLY];
    logic [3:0]  r_vec_d [0:DLY];

    logic [RB-1:0] w_root;
    logic [QB-1:0] w_quo [0:2];
    logic [2*RB-1:0] w_rad;

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PLEN-1:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0 <= '{i_action, i_ax, i_ay, i_az, i_bx, i_by, i_bz, i_factor};
    end

    // Stage 1: select multiplier operands.
    always_comb begin
        t_diff ax, ay, az, bx, by, bz, k, dx, dy, dz;
        ax = t_diff'(r_s0.ax); ay = t_diff'(r_s0.ay); az = t_diff'(r_s0.az);
        bx = t_diff'(r_s0.bx); by = t_diff'(r_s0.by); bz = t_diff'(r_s0.bz);
        k  = t_diff'(r_s0.k);
        dx = bx - ax; dy = by - ay; dz = bz - az;
        for (int i = 0; i < 6; i++) begin
            r_p0[i] = '0;
            r_p1[i] = '0;
        end
        unique case (r_s0.action)
            v3a_pkg::ACT_SCALE: begin
                r_p0[0] = ax; r_p1[0] = k; r_p0[1] = ay; r_p1[1] = k;
                r_p0[2] = az; r_p1[2] = k;
            end
            v3a_pkg::ACT_DOT: begin
                r_p0[0] = ax; r_p1[0] = bx; r_p0[1] = ay; r_p1[1] = by;
                r_p0[2] = az; r_p1[2] = bz;
            end
            v3a_pkg::ACT_CROSS: begin
                r_p0[0] = ay; r_p1[0] = bz; r_p0[3] = az; r_p1[3] = by;
                r_p0[1] = az; r_p1[1] = bx; r_p0[4] = ax; r_p1[4] = bz;
                r_p0[2] = ax; r_p1[2] = by; r_p0[5] = ay; r_p1[5] = bx;
            end
            v3a_pkg::ACT_SQNORM, v3a_pkg::ACT_NORM, v3a_pkg::ACT_NORMALIZE: begin
                r_p0[0] = ax; r_p1[0] = ax; r_p0[1] = ay; r_p1[1] = ay;
                r_p0[2] = az; r_p1[2] = az;
            end
            v3a_pkg::ACT_DIST: begin
                r_p0[0] = dx; r_p1[0] = dx; r_p0[1] = dy; r_p1[1] = dy;
                r_p0[2] = dz; r_p1[2] = dz;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        logic signed [WB:0] ta, tb;
        for (int i = 0; i < 6; i++) begin
            r_prod[i] <= t_prod'(r_p0[i] * r_p1[i]);
        end
        for (int i = 0; i < 3; i++) begin
            ta = (i == 0) ? t_diff'(r_s0.ax) : (i == 1) ? t_diff'(r_s0.ay) : t_diff'(r_s0.az);
            tb = (i == 0) ? t_diff'(r_s0.bx) : (i == 1) ? t_diff'(r_s0.by) : t_diff'(r_s0.bz);
            unique case (r_s0.action)
                v3a_pkg::ACT_ADD: r_add[i] <= ta + tb;
                v3a_pkg::ACT_SUB: r_add[i] <= ta - tb;
                v3a_pkg::ACT_NEG: r_add[i] <= -ta;
                default: r_add[i] <= ta;
            endcase
            r_sgn_mag[i] <= ta[WB] ? WB'(-ta) : WB'(ta);
        end
        r_act1 <= r_s0.action;
        r_eq1  <= (r_s0.ax == r_s0.bx) && (r_s0.ay == r_s0.by) && (r_s0.az == r_s0.bz);
    end

    // Stage 2: sums and shifts at full width.
    always_ff @(posedge i_clk) begin
        v3a_pkg::t_wide sum3;
        v3a_pkg::t_wide n_res [0:3];
        sum3 = v3a_pkg::t_wide'(r_prod[0]) + v3a_pkg::t_wide'(r_prod[1])
             + v3a_pkg::t_wide'(r_prod[2]);
        r_act2 <= r_act1;
        r_eq2  <= r_eq1;
        for (int i = 0; i < 3; i++) begin
            r_neg2[i] <= r_add[i][WB];
        end
        for (int i = 0; i < 4; i++) begin
            n_res[i] = '0;
        end
        unique case (r_act1)
            v3a_pkg::ACT_ADD, v3a_pkg::ACT_SUB, v3a_pkg::ACT_NEG: begin
                for (int i = 0; i < 3; i++) begin
                    n_res[i] = v3a_pkg::t_wide'($signed(r_add[i]));
                end
            end
            v3a_pkg::ACT_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    n_res[i] = v3a_pkg::t_wide'(r_prod[i]) >>> FB;
                end
            end
            v3a_pkg::ACT_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    n_res[i] = (v3a_pkg::t_wide'(r_prod[i])
                                - v3a_pkg::t_wide'(r_prod[i+3])) >>> FB;
                end
            end
            v3a_pkg::ACT_DOT, v3a_pkg::ACT_SQNORM: n_res[3] = sum3 >>> FB;
            v3a_pkg::ACT_NORM, v3a_pkg::ACT_NORMALIZE, v3a_pkg::ACT_DIST: begin
                n_res[3] = sum3;
                for (int i = 0; i < 3; i++) begin
                    n_res[i] = v3a_pkg::t_wide'({1'b0, r_sgn_mag[i]});
                end
            end
            default: begin
            end
        endcase
        r_res <= n_res;
    end

    assign w_rad = (2*RB)'(r_res[3]);

    v3a_sqrt u_sqrt (.i_clk(i_clk), .i_rad(w_rad), .o_root(w_root));

    // Align everything else with the root, then with the quotients.
    always_ff @(posedge i_clk) begin
        r_act_d[0] <= r_act2;
        r_eq_d[0]  <= r_eq2;
        r_vec_d[0] <= {1'b0, r_neg2};
        for (int s = 0; s < DLY; s++) begin
            r_act_d[s+1] <= r_act_d[s];
            r_eq_d[s+1]  <= r_eq_d[s];
            r_vec_d[s+1] <= r_vec_d[s];
        end
    end

    v3a_pkg::t_wide r_sq [0:RB][0:3];
    always_ff @(posedge i_clk) begin
        r_sq[0] <= r_res;
        for (int s = 0; s < RB; s++) begin
            r_sq[s+1] <= r_sq[s];
        end
    end

    logic [RB-1:0] w_den;
    assign w_den = (w_root == '0) ? RB'(1) : w_root;
    for (genvar i = 0; i < 3; i++) begin : g_div
        v3a_div u_div (
            .i_clk(i_clk),
            .i_num(QB'(r_sq[RB][i]) << FB),
            .i_den(w_den),
            .o_quo(w_quo[i])
        );
    end

    v3a_pkg::t_wide r_qd [0:QB][0:3];
    logic [RB-1:0] r_rootd [0:QB];
    always_ff @(posedge i_clk) begin
        r_qd[0]    <= r_sq[RB];
        r_rootd[0] <= w_root;
        for (int s = 0; s < QB; s++) begin
            r_qd[s+1]    <= r_qd[s];
            r_rootd[s+1] <= r_rootd[s];
        end
    end

    // Final stage: saturate and register the result.
    always_ff @(posedge i_clk) begin
        logic [3:0] act;
        logic o0, o1, o2, o3, zd;
        v3a_pkg::t_wide q;
        v3a_pkg::t_word v0, v1, v2, v3;
        act = r_act_d[DLY];
        v0 = v3a_pkg::sat_word(r_qd[QB][0], o0);
        v1 = v3a_pkg::sat_word(r_qd[QB][1], o1);
        v2 = v3a_pkg::sat_word(r_qd[QB][2], o2);
        v3 = v3a_pkg::sat_word(r_qd[QB][3], o3);
        zd = 1'b0;
        o_strobe <= r_vld[PLEN] && i_rst_n;
        o_equal_flag <= (act == v3a_pkg::ACT_EQUAL) && r_eq_d[DLY];
        unique case (act)
            v3a_pkg::ACT_ADD, v3a_pkg::ACT_SUB, v3a_pkg::ACT_NEG,
            v3a_pkg::ACT_SCALE, v3a_pkg::ACT_CROSS: begin
                o_rx <= v0; o_ry <= v1; o_rz <= v2; o_scalar_out <= '0;
                o_overflow_flag <= o0 | o1 | o2;
            end
            v3a_pkg::ACT_DOT, v3a_pkg::ACT_SQNORM: begin
                o_rx <= '0; o_ry <= '0; o_rz <= '0; o_scalar_out <= v3;
                o_overflow_flag <= o3;
            end
            v3a_pkg::ACT_NORM, v3a_pkg::ACT_DIST: begin
                q = v3a_pkg::t_wide'({1'b0, r_rootd[QB]});
                o_rx <= '0; o_ry <= '0; o_rz <= '0;
                o_scalar_out <= v3a_pkg::sat_word(q, o0);
                o_overflow_flag <= o0;
            end
            v3a_pkg::ACT_NORMALIZE: begin
                zd = (r_rootd[QB] == '0);
                if (zd) begin
                    o_rx <= '0; o_ry <= '0; o_rz <= '0;
                    o_overflow_flag <= 1'b0;
                end else begin
                    q = v3a_pkg::t_wide'({1'b0, w_quo[0]});
                    v0 = v3a_pkg::sat_word(r_vec_d[DLY][0] ? -q : q, o0);
                    q = v3a_pkg::t_wide'({1'b0, w_quo[1]});
                    v1 = v3a_pkg::sat_word(r_vec_d[DLY][1] ? -q : q, o1);
                    q = v3a_pkg::t_wide'({1'b0, w_quo[2]});
                    v2 = v3a_pkg::sat_word(r_vec_d[DLY][2] ? -q : q, o2);
                    o_rx <= v0; o_ry <= v1; o_rz <= v2;
                    o_overflow_flag <= o0 | o1 | o2;
                end
                o_scalar_out <= '0;
            end
            default: begin
                o_rx <= '0; o_ry <= '0; o_rz <= '0; o_scalar_out <= '0;
                o_overflow_flag <= 1'b0;
            end
        endcase
        o_zero_div_flag <= zd;
    end

    `V3A_ASSERT_IMPL(a_never_busy, i_clk, i_rst_n, 1'b1, !o_busy)
    `V3A_ASSERT_IMPL(a_flags_excl, i_clk, i_rst_n, o_strobe, !(o_equal_flag && o_zero_div_flag))
    `V3A_ASSERT_NEXT(a_strobe_follows, i_clk, i_rst_n, r_vld[PLEN], o_strobe)
endmodule
`default_nettype wire

[rtl/v3a_sqrt.sv]
// Pipelined square root, one result bit per stage, restoring form.
// Depends on v3a_pkg.
`default_nettype none
module v3a_sqrt (
    input  wire logic                           i_clk,
    input  wire logic [2*v3a_pkg::ROOT_BITS-1:0] i_rad,
    output logic      [v3a_pkg::ROOT_BITS-1:0]   o_root
);
    localparam int RB = v3a_pkg::ROOT_BITS;
    localparam int SB = 2 * RB;
    logic [SB-1:0] r_rad  [0:RB];
    logic [SB+1:0] r_rem  [0:RB];
    logic [RB-1:0] r_root [0:RB];

    always_ff @(posedge i_clk) begin
        r_rad[0]  <= i_rad;
        r_rem[0]  <= '0;
        r_root[0] <= '0;
    end

    for (genvar s = 0; s < RB; s++) begin : g_st
        logic [SB+1:0] n_rem, n_trial;
        always_comb begin
            n_rem   = {r_rem[s][SB-1:0], r_rad[s][SB-1 -: 2]};
            n_trial = {{(SB-RB){1'b0}}, r_root[s], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            r_rad[s+1] <= r_rad[s] << 2;
            if (n_rem >= n_trial) begin
                r_rem[s+1]  <= n_rem - n_trial;
                r_root[s+1] <= {r_root[s][RB-2:0], 1'b1};
            end else begin
                r_rem[s+1]  <= n_rem;
                r_root[s+1] <= {r_root[s][RB-2:0], 1'b0};
            end
        end
    end
    assign o_root = r_root[RB];
endmodule
`default_nettype wire

[rtl/v3a_div.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on v3a_pkg.
`default_nettype none
module v3a_div (
    input  wire logic                          i_clk,
    input  wire logic [v3a_pkg::QUO_BITS-1:0]  i_num,
    input  wire logic [v3a_pkg::ROOT_BITS-1:0] i_den,
    output logic      [v3a_pkg::QUO_BITS-1:0]  o_quo
);
    localparam int QB = v3a_pkg::QUO_BITS;
    localparam int DB = v3a_pkg::ROOT_BITS;
    logic [QB-1:0] r_num [0:QB];
    logic [DB-1:0] r_den [0:QB];
    logic [DB:0]   r_rem [0:QB];

    always_ff @(posedge i_clk) begin
        r_num[0] <= i_num;
        r_den[0] <= i_den;
        r_rem[0] <= '0;
    end

    for (genvar s = 0; s < QB; s++) begin : g_st
        logic [DB:0] n_rem;
        assign n_rem = {r_rem[s][DB-1:0], r_num[s][QB-1]};
        always_ff @(posedge i_clk) begin
            r_den[s+1] <= r_den[s];
            if (n_rem >= {1'b0, r_den[s]}) begin
                r_rem[s+1] <= n_rem - {1'b0, r_den[s]};
                r_num[s+1] <= {r_num[s][QB-2:0], 1'b1};
            end else begin
                r_rem[s+1] <= n_rem;
                r_num[s+1] <= {r_num[s][QB-2:0], 1'b0};
            end
        end
    end
    assign o_quo = r_num[QB];
endmodule
`default_nettype wire
